// File: hw/rtl/cia_dsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the status word decoder of the CiA 402 drive state controller.
// No dependencies.

package cia_dsc_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned ModeW  = 8;
	localparam int unsigned VelW   = 32;
	localparam int unsigned StepW  = 24;
	localparam int unsigned CmdW   = 2;
	localparam int unsigned CtrlW  = 10;
	localparam int unsigned CfgIdxW = 1;

	localparam logic signed [ModeW-1:0] ModeCsv      = 8'sd9;
	localparam logic signed [ModeW-1:0] ModeResetVal = 8'sd8;

	// status word bits
	localparam int unsigned SwReady    = 0;
	localparam int unsigned SwSwOn     = 1;
	localparam int unsigned SwOpEn     = 2;
	localparam int unsigned SwFault    = 3;
	localparam int unsigned SwQsOff    = 5;
	localparam int unsigned SwOnDis    = 6;

	// control bit patterns (b0 switch on, b1 voltage, b2 quick stop off, b3 enable op)
	localparam logic [3:0] CtrlEnable  = 4'hF;
	localparam logic [3:0] CtrlDisable = 4'h6;
	localparam int unsigned CtrlQsBit  = 2;
	localparam int unsigned CwFaultRst = 7;

	typedef enum logic [2:0] {
		ST_NOT_READY      = 3'd0,
		ST_SWITCH_ON_DIS  = 3'd1,
		ST_READY          = 3'd2,
		ST_SWITCHED_ON    = 3'd3,
		ST_OP_ENABLED     = 3'd4,
		ST_QUICK_STOP     = 3'd5,
		ST_FAULT_REACTION = 3'd6,
		ST_FAULT          = 3'd7
	} drive_state_t;

	typedef enum logic [CmdW-1:0] {
		CMD_NONE    = 2'd0,
		CMD_ENABLE  = 2'd1,
		CMD_DISABLE = 2'd2,
		CMD_QSTOP   = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_REQUESTED_MODE = 1'd0,
		REG_VELOCITY_STEP  = 1'd1
	} cfg_reg_t;

	function automatic drive_state_t decode_state(input logic [WordW-1:0] sw);
		drive_state_t st;
		if (!sw[SwReady]) begin
			if (sw[SwOnDis])     st = ST_SWITCH_ON_DIS;
			else if (sw[SwFault]) st = ST_FAULT;
			else                  st = ST_NOT_READY;
		end else if (sw[SwFault]) begin
			st = ST_FAULT_REACTION;
		end else if (!sw[SwQsOff]) begin
			st = ST_QUICK_STOP;
		end else if (sw[SwOpEn]) begin
			st = ST_OP_ENABLED;
		end else if (sw[SwSwOn]) begin
			st = ST_SWITCHED_ON;
		end else begin
			st = ST_READY;
		end
		return st;
	endfunction

endpackage

// File: hw/rtl/cia_dsc_in_if.sv
`timescale 1ns / 1ps
// Request channel of the drive state controller: one fieldbus cycle per request.
// Depends on cia_dsc_pkg.

interface cia_dsc_in_if;
	logic                                       valid;
	logic                                       ready;
	logic [cia_dsc_pkg::WordW-1:0]              status_word;
	logic [cia_dsc_pkg::WordW-1:0]              error_code;
	logic [cia_dsc_pkg::WordW-1:0]              sto_word;
	logic signed [cia_dsc_pkg::ModeW-1:0]       mode_actual;
	logic signed [cia_dsc_pkg::VelW-1:0]        velocity_command;
	logic [cia_dsc_pkg::CmdW-1:0]               command;

	modport source (output valid, status_word, error_code, sto_word, mode_actual,
		velocity_command, command, input ready);
	modport sink (input valid, status_word, error_code, sto_word, mode_actual,
		velocity_command, command, output ready);
endinterface

// File: hw/rtl/cia_dsc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the drive state controller.
// Depends on cia_dsc_pkg.

interface cia_dsc_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [2:0]                            drive_state;
	logic [cia_dsc_pkg::CtrlW-1:0]         control_word;
	logic signed [cia_dsc_pkg::ModeW-1:0]  mode_request;
	logic signed [cia_dsc_pkg::VelW-1:0]   velocity_setpoint;
	logic                                  state_event;
	logic                                  error_event;
	logic                                  estop_active;
	logic                                  estop_event;
	logic                                  drive_ready;
	logic                                  drive_enabled;

	modport source (output valid, drive_state, control_word, mode_request, velocity_setpoint,
		state_event, error_event, estop_active, estop_event, drive_ready, drive_enabled,
		input ready);
	modport sink (input valid, drive_state, control_word, mode_request, velocity_setpoint,
		state_event, error_event, estop_active, estop_event, drive_ready, drive_enabled,
		output ready);
endinterface

// File: hw/rtl/cia_dsc_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the drive state controller.
// Depends on cia_dsc_pkg.

interface cia_dsc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [cia_dsc_pkg::CfgIdxW-1:0]     index;
	logic [cia_dsc_pkg::StepW-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/cia_dsc_ramp.sv
`timescale 1ns / 1ps
// Velocity ramp: one step of the profile velocity toward the command, clamped at the command.
// Depends on cia_dsc_pkg.

module cia_dsc_ramp (
	input  logic signed [cia_dsc_pkg::VelW-1:0]  ramp,
	input  logic signed [cia_dsc_pkg::VelW-1:0]  target,
	input  logic [cia_dsc_pkg::StepW-1:0]        step,
	output logic signed [cia_dsc_pkg::VelW-1:0] ramp_next
);
	localparam int unsigned ExtW = cia_dsc_pkg::VelW + 2;

	logic signed [ExtW-1:0] p_ext;
	logic signed [ExtW-1:0] c_ext;
	logic signed [ExtW-1:0] s_ext;
	logic signed [ExtW-1:0] up;
	logic signed [ExtW-1:0] dn;

	assign p_ext = {{2{ramp[cia_dsc_pkg::VelW-1]}}, ramp};
	assign c_ext = {{2{target[cia_dsc_pkg::VelW-1]}}, target};
	assign s_ext = {{(ExtW - cia_dsc_pkg::StepW){1'b0}}, step};
	assign up    = p_ext + s_ext;
	assign dn    = p_ext - s_ext;

	always_comb begin
		if (target > ramp) begin
			ramp_next = (up > c_ext) ? target : up[cia_dsc_pkg::VelW-1:0];
		end else if (target < ramp) begin
			ramp_next = (dn < c_ext) ? target : dn[cia_dsc_pkg::VelW-1:0];
		end else begin
			ramp_next = ramp;
		end
	end
endmodule

// File: hw/rtl/cia402_drive_state_controller.sv
`timescale 1ns / 1ps
// CiA 402 drive state controller. A request passes the input register, then the result
// register. Throughput: one request per cycle while the result side is not stalled;
// the decode and the single ramp add-and-clamp sit between the two registers.
// Reset (arst_n low, asynchronous) empties both stages, clears the drive state
// to not ready and all history, requested_mode to 8 and velocity_step to 0.
// Depends on cia_dsc_pkg, the channel interfaces and cia_dsc_ramp.

module cia402_drive_state_controller (
	input  logic          clk,
	input  logic          arst_n,
	cia_dsc_in_if.sink    item,
	cia_dsc_out_if.source result,
	cia_dsc_cfg_if.sink   cfg
);
	// configuration
	logic signed [cia_dsc_pkg::ModeW-1:0] mode_q;
	logic [cia_dsc_pkg::StepW-1:0]        step_q;

	// input stage
	logic                                  valid_s1;
	logic [cia_dsc_pkg::WordW-1:0]         status_s1;
	logic [cia_dsc_pkg::WordW-1:0]         error_s1;
	logic [cia_dsc_pkg::WordW-1:0]         sto_s1;
	logic signed [cia_dsc_pkg::ModeW-1:0]  mode_act_s1;
	logic signed [cia_dsc_pkg::VelW-1:0]   vcmd_s1;
	logic [cia_dsc_pkg::CmdW-1:0]          cmd_s1;

	// controller history
	cia_dsc_pkg::drive_state_t             state_q;
	logic [cia_dsc_pkg::WordW-1:0]         prev_error_q;
	logic                                  estop_q;
	logic                                  fault_rst_q;
	logic [3:0]                            ctrl_q;
	logic signed [cia_dsc_pkg::VelW-1:0]   ramp_q;

	// result register
	logic                                  out_valid_q;
	cia_dsc_pkg::drive_state_t             out_state_q;
	logic [cia_dsc_pkg::CtrlW-1:0]         out_cw_q;
	logic signed [cia_dsc_pkg::ModeW-1:0]  out_mode_q;
	logic signed [cia_dsc_pkg::VelW-1:0]   out_vel_q;
	logic                                  out_state_ev_q;
	logic                                  out_err_ev_q;
	logic                                  out_estop_q;
	logic                                  out_estop_ev_q;

	logic                                  advance;
	cia_dsc_pkg::drive_state_t             st_new;
	logic                                  state_ev;
	logic                                  err_ev;
	logic                                  estop_now;
	logic                                  estop_ev;
	logic                                  do_enable;
	logic                                  do_disable;
	logic                                  do_qstop;
	logic signed [cia_dsc_pkg::VelW-1:0]   ramp_step;
	logic signed [cia_dsc_pkg::VelW-1:0]   ramp_new;
	logic                                  fault_rst_new;
	logic [3:0]                            ctrl_new;
	logic [cia_dsc_pkg::CtrlW-1:0]         cw_new;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cia_dsc_pkg::ModeResetVal;
			step_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				cia_dsc_pkg::REG_REQUESTED_MODE: mode_q <= cfg.data[cia_dsc_pkg::ModeW-1:0];
				cia_dsc_pkg::REG_VELOCITY_STEP:  step_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			status_s1   <= item.status_word;
			error_s1    <= item.error_code;
			sto_s1      <= item.sto_word;
			mode_act_s1 <= item.mode_actual;
			vcmd_s1     <= item.velocity_command;
			cmd_s1      <= item.command;
		end
	end

	cia_dsc_ramp u_ramp (
		.ramp      (ramp_q),
		.target    (vcmd_s1),
		.step      (step_q),
		.ramp_next (ramp_step)
	);

	always_comb begin
		st_new    = cia_dsc_pkg::decode_state(status_s1);
		state_ev  = (st_new != state_q) && (st_new != cia_dsc_pkg::ST_FAULT);
		err_ev    = (error_s1 != prev_error_q) && (error_s1 != '0);
		estop_now = (sto_s1 == '0);
		estop_ev  = estop_now != estop_q;

		do_enable  = cmd_s1 == cia_dsc_pkg::CMD_ENABLE;
		// a new error or a fresh emergency stop forces a disable
		do_disable = (cmd_s1 == cia_dsc_pkg::CMD_DISABLE) || err_ev || (estop_ev && estop_now);
		do_qstop   = cmd_s1 == cia_dsc_pkg::CMD_QSTOP;

		if (do_enable || do_disable) begin
			ramp_new = '0;
		end else if (mode_act_s1 == cia_dsc_pkg::ModeCsv) begin
			ramp_new = ramp_step;
		end else begin
			ramp_new = ramp_q;
		end

		// toggle fault reset while an error stays reported
		fault_rst_new = fault_rst_q ? 1'b0 : (error_s1 != '0);

		ctrl_new = ctrl_q;
		if (do_qstop)   ctrl_new[cia_dsc_pkg::CtrlQsBit] = 1'b0;
		if (do_enable)  ctrl_new = cia_dsc_pkg::CtrlEnable;
		if (do_disable) ctrl_new = cia_dsc_pkg::CtrlDisable;

		cw_new = {{(cia_dsc_pkg::CtrlW - 4){1'b0}}, ctrl_new};
		cw_new[cia_dsc_pkg::CwFaultRst] = fault_rst_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cia_dsc_pkg::ST_NOT_READY;
			prev_error_q <= '0;
			estop_q      <= 1'b0;
			fault_rst_q  <= 1'b0;
			ctrl_q       <= '0;
			ramp_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				state_q      <= st_new;
				prev_error_q <= error_s1;
				estop_q      <= estop_now;
				fault_rst_q  <= fault_rst_new;
				ctrl_q       <= ctrl_new;
				ramp_q       <= ramp_new;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q    <= st_new;
			out_cw_q       <= cw_new;
			out_mode_q     <= mode_q;
			out_vel_q      <= ramp_new;
			out_state_ev_q <= state_ev;
			out_err_ev_q   <= err_ev;
			out_estop_q    <= estop_now;
			out_estop_ev_q <= estop_ev;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.drive_state       = out_state_q;
	assign result.control_word      = out_cw_q;
	assign result.mode_request      = out_mode_q;
	assign result.velocity_setpoint = out_vel_q;
	assign result.state_event       = out_state_ev_q;
	assign result.error_event       = out_err_ev_q;
	assign result.estop_active      = out_estop_q;
	assign result.estop_event       = out_estop_ev_q;
	assign result.drive_ready       = (out_state_q == cia_dsc_pkg::ST_READY)
		|| (out_state_q == cia_dsc_pkg::ST_SWITCHED_ON)
		|| (out_state_q == cia_dsc_pkg::ST_OP_ENABLED);
	assign result.drive_enabled     = out_state_q == cia_dsc_pkg::ST_OP_ENABLED;
endmodule

// File: hw/rtl/cia_dsc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the drive state controller, attached by bind.
// Depends on cia_dsc_pkg and cia402_drive_state_controller.

module cia_dsc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cia_dsc_pkg::CtrlW-1:0]   control_word,
	input logic signed [cia_dsc_pkg::VelW-1:0] velocity_setpoint,
	input logic                            error_event,
	input logic                            estop_active,
	input logic                            estop_event,
	input logic                            drive_ready,
	input logic                            drive_enabled
);
	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(control_word)
			&& $stable(velocity_setpoint))
		else $error("stalled result changed");

	// a new error forces a disable and zeroes the ramp
	a_err_disable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_event |->
			control_word[3:0] == cia_dsc_pkg::CtrlDisable && velocity_setpoint == '0)
		else $error("error event without forced disable");

	// an emergency stop going active forces a disable
	a_estop_disable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && estop_event && estop_active |->
			control_word[3:0] == cia_dsc_pkg::CtrlDisable && velocity_setpoint == '0)
		else $error("estop onset without forced disable");

	a_enabled_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_enabled |-> drive_ready
			&& control_word[6:4] == '0
			&& control_word[cia_dsc_pkg::CtrlW-1:cia_dsc_pkg::CwFaultRst+1] == '0)
		else $error("inconsistent result flags");
endmodule

bind cia402_drive_state_controller cia_dsc_checker u_cia_dsc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.control_word      (result.control_word),
	.velocity_setpoint (result.velocity_setpoint),
	.error_event       (result.error_event),
	.estop_active      (result.estop_active),
	.estop_event       (result.estop_event),
	.drive_ready       (result.drive_ready),
	.drive_enabled     (result.drive_enabled)
);

// File: test/tb_cia402_drive_state_controller.sv
`timescale 1ns / 1ps
// Testbench of cia402_drive_state_controller: a directed table, then random fieldbus cycles,
// each result checked against a behavioural predictor of the drive state controller.
// Depends on cia_dsc_pkg, the channel interfaces and the controller itself.

module tb_cia402_drive_state_controller;
	import cia_dsc_pkg::*;

	localparam int SettleCycles      = 4;
	localparam int DirectedResetRows = 4;
	localparam int RandomPhases      = 5;
	localparam int PhaseRequests     = 150;
	localparam int HoldStart         = 400;
	localparam int HoldLen           = 120;
	localparam logic [WordW-1:0] UnusedStatusBits = 16'hFF90;

	typedef struct packed {
		logic [WordW-1:0]        status_word;
		logic [WordW-1:0]        error_code;
		logic [WordW-1:0]        sto_word;
		logic signed [ModeW-1:0] mode_actual;
		logic signed [VelW-1:0]  velocity_command;
		cmd_t                    command;
	} fb_cycle_t;

	typedef struct packed {
		drive_state_t            drive_state;
		logic [CtrlW-1:0]        control_word;
		logic signed [ModeW-1:0] mode_request;
		logic signed [VelW-1:0]  velocity_setpoint;
		logic                    state_event;
		logic                    error_event;
		logic                    estop_active;
		logic                    estop_event;
		logic                    drive_ready;
		logic                    drive_enabled;
	} drive_result_t;

	// flags: {state_event, error_event, estop_active, estop_event}
	typedef struct packed {
		fb_cycle_t        req;
		bit               typed;
		drive_state_t     st;
		logic [CtrlW-1:0] cw;
		logic [3:0]       flags;
	} drive_vector_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cia_dsc_in_if  req_ch ();
	cia_dsc_out_if res_ch ();
	cia_dsc_cfg_if cfg_ch ();

	cia402_drive_state_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// predictor copy of the controller state and registers
	drive_state_t            last_state;
	logic [WordW-1:0]        last_error;
	logic                    estop_latched;
	logic                    fault_rst;
	logic [3:0]              ctrl_bits;
	logic signed [VelW-1:0]  ramp_vel;
	logic signed [ModeW-1:0] mode_reg;
	logic [StepW-1:0]        vel_step;

	// slowly changing random content
	logic [WordW-1:0]        held_error  = '0;
	logic [WordW-1:0]        held_sto    = 16'hFFFF;
	logic signed [VelW-1:0]  held_target = '0;

	drive_result_t expected_results[$];
	drive_vector_t directed_rows[$];
	int            mismatches   = 0;
	int            results_seen = 0;

	function automatic drive_state_t status_to_state(input logic [WordW-1:0] sw);
		if (!sw[SwReady])
			return sw[SwOnDis] ? ST_SWITCH_ON_DIS : (sw[SwFault] ? ST_FAULT : ST_NOT_READY);
		if (sw[SwFault])
			return ST_FAULT_REACTION;
		if (!sw[SwQsOff])
			return ST_QUICK_STOP;
		if (sw[SwOpEn])
			return ST_OP_ENABLED;
		return sw[SwSwOn] ? ST_SWITCHED_ON : ST_READY;
	endfunction

	function automatic drive_result_t advance_drive(input fb_cycle_t c);
		drive_result_t r;
		drive_state_t  st;
		logic          err_ev, estop_now, estop_ev, go, stop;
		longint        pos, tgt;
		st = status_to_state(c.status_word);
		r.state_event = (st != last_state) && (st != ST_FAULT);
		last_state = st;

		err_ev = (c.error_code != last_error) && (c.error_code != '0);
		last_error = c.error_code;
		estop_now = (c.sto_word == '0);
		estop_ev = (estop_now != estop_latched);
		estop_latched = estop_now;

		go = (c.command == CMD_ENABLE);
		// a new error or an estop going active forces a disable; a release forces nothing
		stop = (c.command == CMD_DISABLE) || err_ev || (estop_ev && estop_now);

		if (go || stop) begin
			ramp_vel = '0;
		end else if (c.mode_actual == ModeCsv) begin
			pos = longint'(ramp_vel);
			tgt = longint'($signed(c.velocity_command));
			if (tgt > pos) begin
				pos = pos + longint'(vel_step);
				if (pos > tgt) pos = tgt;
			end else if (tgt < pos) begin
				pos = pos - longint'(vel_step);
				if (pos < tgt) pos = tgt;
			end
			ramp_vel = 32'(pos);
		end

		fault_rst = fault_rst ? 1'b0 : (c.error_code != '0);
		if (c.command == CMD_QSTOP) ctrl_bits[CtrlQsBit] = 1'b0;
		if (go) ctrl_bits = CtrlEnable;
		if (stop) ctrl_bits = CtrlDisable;

		r.drive_state = st;
		r.control_word = '0;
		r.control_word[3:0] = ctrl_bits;
		r.control_word[CwFaultRst] = fault_rst;
		r.mode_request = mode_reg;
		r.velocity_setpoint = ramp_vel;
		r.error_event = err_ev;
		r.estop_active = estop_now;
		r.estop_event = estop_ev;
		r.drive_ready = (st == ST_READY) || (st == ST_SWITCHED_ON) || (st == ST_OP_ENABLED);
		r.drive_enabled = (st == ST_OP_ENABLED);
		return r;
	endfunction

	function automatic drive_vector_t directed_row(input logic [WordW-1:0] sw,
			input logic [WordW-1:0] err, input logic [WordW-1:0] sto,
			input logic signed [ModeW-1:0] mode, input logic signed [VelW-1:0] vcmd,
			input cmd_t cmd, input bit typed, input drive_state_t st,
			input logic [CtrlW-1:0] cw, input logic [3:0] flags);
		drive_vector_t v;
		v.req = '{sw, err, sto, mode, vcmd, cmd};
		v.typed = typed;
		v.st = st;
		v.cw = cw;
		v.flags = flags;
		return v;
	endfunction

	// append one row to the directed table
	task automatic queue_row(input drive_vector_t v);
		directed_rows.insert(directed_rows.size(), v);
	endtask

	// mostly well-formed status words with slowly changing error, estop and target
	function automatic fb_cycle_t random_cycle();
		fb_cycle_t    c;
		drive_state_t pick;
		int           roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			c.status_word = 16'($urandom);
			c.error_code = 16'($urandom);
			c.sto_word = 16'($urandom);
			c.mode_actual = 8'($urandom);
			c.velocity_command = 32'($urandom);
			c.command = cmd_t'(2'($urandom));
			return c;
		end
		pick = drive_state_t'(3'($urandom));
		case (pick)
			ST_NOT_READY:      c.status_word = 16'h0000;
			ST_SWITCH_ON_DIS:  c.status_word = 16'h0040;
			ST_READY:          c.status_word = 16'h0021;
			ST_SWITCHED_ON:    c.status_word = 16'h0023;
			ST_OP_ENABLED:     c.status_word = 16'h0027;
			ST_QUICK_STOP:     c.status_word = 16'h0007;
			ST_FAULT_REACTION: c.status_word = 16'h000F;
			default:           c.status_word = 16'h0008;
		endcase
		if ($urandom_range(0, 1) == 1)
			c.status_word = c.status_word | (16'($urandom) & UnusedStatusBits);

		roll = $urandom_range(0, 99);
		if (roll < 4) held_error = 16'($urandom);
		else if (roll < 14) held_error = '0;
		c.error_code = held_error;

		if ($urandom_range(0, 19) == 0)
			held_sto = (held_sto == '0) ? 16'($urandom_range(1, 65535)) : '0;
		c.sto_word = held_sto;

		c.mode_actual = ($urandom_range(0, 4) != 0) ? ModeCsv : 8'($urandom);

		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			held_target = 32'($urandom);
		end else if (roll < 7) begin
			held_target = 32'($urandom_range(0, 40000)) - 32'sd20000;
		end else if (roll < 9) begin
			case ($urandom_range(0, 3))
				0:       held_target = 32'sh7FFFFFFF;
				1:       held_target = 32'sh80000000;
				2:       held_target = '0;
				default: held_target = -32'sd1;
			endcase
		end
		c.velocity_command = held_target;
		c.command = ($urandom_range(0, 7) != 0) ? CMD_NONE : cmd_t'(2'($urandom));
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40) $display("mismatch: %s", what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got,
				want));
	endtask

	task automatic send_cycle(input fb_cycle_t c);
		req_ch.status_word      <= c.status_word;
		req_ch.error_code       <= c.error_code;
		req_ch.sto_word         <= c.sto_word;
		req_ch.mode_actual      <= c.mode_actual;
		req_ch.velocity_command <= c.velocity_command;
		req_ch.command          <= c.command;
		req_ch.valid            <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// both registers back to back; valid stays high between the two writes
	task automatic program_registers(input logic signed [ModeW-1:0] mode,
			input logic [StepW-1:0] step);
		cfg_ch.index <= REG_REQUESTED_MODE;
		cfg_ch.data  <= {{(StepW-ModeW){mode[ModeW-1]}}, mode};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		mode_reg = mode;
		cfg_ch.index <= REG_VELOCITY_STEP;
		cfg_ch.data  <= step;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		vel_step = step;
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		drive_result_t want;
		drive_vector_t row;
		int            burst_left;
		int            idle;
		req_ch.valid            <= 1'b0;
		req_ch.status_word      <= '0;
		req_ch.error_code       <= '0;
		req_ch.sto_word         <= '0;
		req_ch.mode_actual      <= '0;
		req_ch.velocity_command <= '0;
		req_ch.command          <= CMD_NONE;
		cfg_ch.valid            <= 1'b0;
		cfg_ch.index            <= REG_REQUESTED_MODE;
		cfg_ch.data             <= '0;

		// first rows run under the reset register values
		queue_row(directed_row(16'h0000, 16'h0000, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_NONE, 1'b1, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0040, 16'h0000, 16'h0001, ModeCsv, 32'sd5000,
			CMD_NONE, 1'b1, ST_SWITCH_ON_DIS, 10'h000, 4'b1000));
		queue_row(directed_row(16'h0021, 16'h0000, 16'h0000, ModeCsv,
			32'sh7FFFFFFF, CMD_ENABLE, 1'b1, ST_READY, 10'h006, 4'b1011));
		queue_row(directed_row(16'h0021, 16'h0000, 16'h0000, ModeCsv, -32'sd1,
			CMD_ENABLE, 1'b1, ST_READY, 10'h00F, 4'b0010));
		queue_row(directed_row(16'h0023, 16'h0000, 16'hFFFF, ModeCsv, 32'sd2500,
			CMD_NONE, 1'b1, ST_SWITCHED_ON, 10'h00F, 4'b1001));
		queue_row(directed_row(16'h0027, 16'h0000, 16'h8000, ModeCsv, 32'sd2500,
			CMD_NONE, 1'b1, ST_OP_ENABLED, 10'h00F, 4'b1000));
		queue_row(directed_row(16'hFFB7, 16'h0000, 16'h8000, ModeCsv, 32'sd2500,
			CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'hFFB7, 16'h0000, 16'h8000, ModeCsv,
			32'sh80000000, CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'hFFB7, 16'h0000, 16'h8000, ModeCsv,
			32'sh80000000, CMD_QSTOP, 1'b1, ST_OP_ENABLED, 10'h00B, 4'b0000));
		queue_row(directed_row(16'h0007, 16'h1234, 16'hFFFF, ModeCsv,
			32'sh80000000, CMD_QSTOP, 1'b1, ST_QUICK_STOP, 10'h086, 4'b1100));
		queue_row(directed_row(16'h000F, 16'h1234, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_NONE, 1'b1, ST_FAULT_REACTION, 10'h006, 4'b1000));
		queue_row(directed_row(16'h0008, 16'h1234, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_NONE, 1'b1, ST_FAULT, 10'h086, 4'b0000));
		queue_row(directed_row(16'h0008, 16'hFFFF, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_ENABLE, 1'b1, ST_FAULT, 10'h006, 4'b0100));
		queue_row(directed_row(16'h0040, 16'h0000, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_DISABLE, 1'b1, ST_SWITCH_ON_DIS, 10'h006, 4'b1000));
		queue_row(directed_row(16'h0021, 16'h0000, 16'hFFFF, ModeCsv,
			32'sh7FFFFFFF, CMD_ENABLE, 1'b1, ST_READY, 10'h00F, 4'b1000));
		queue_row(directed_row(16'h0027, 16'h0000, 16'hFFFF, 8'sd8,
			32'sh7FFFFFFF, CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0027, 16'h0000, 16'hFFFF, ModeCsv,
			32'sh7FFFFFFF, CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0027, 16'h0000, 16'hFFFF, -8'sd128, 32'sd1,
			CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0027, 16'h0000, 16'hFFFF, 8'sd127, 32'sd0,
			CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0027, 16'h0000, 16'hFFFF, ModeCsv, 32'sd1,
			CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'hFFFF, 16'h0001, 16'h0000, ModeCsv,
			32'sh7FFFFFFF, CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'hFFBE, 16'h0001, 16'h0000, ModeCsv,
			32'sh7FFFFFFF, CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));
		queue_row(directed_row(16'h0000, 16'h0000, 16'hFFFF, ModeCsv, 32'sd0,
			CMD_NONE, 1'b0, ST_NOT_READY, 10'h000, 4'b0000));

		last_state    = ST_NOT_READY;
		last_error    = '0;
		estop_latched = 1'b0;
		fault_rst     = 1'b0;
		ctrl_bits     = '0;
		ramp_vel      = '0;
		mode_reg      = ModeResetVal;
		vel_step      = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (i == DirectedResetRows) begin
				req_ch.valid <= 1'b0;
				drain_results();
				program_registers(-8'sd128, 24'd1000);
			end
			send_cycle(row.req);
			want = advance_drive(row.req);
			if (row.typed) begin
				want.drive_state  = row.st;
				want.control_word = row.cw;
				{want.state_event, want.error_event, want.estop_active, want.estop_event} =
					row.flags;
			end
			expected_results.insert(expected_results.size(), want);
		end
		req_ch.valid <= 1'b0;

		for (int ph = 0; ph < RandomPhases; ph++) begin
			drain_results();
			case (ph)
				0:       program_registers(8'sd127, 24'hFFFFFF);
				1:       program_registers(-8'sd128, 24'd0);
				2:       program_registers(ModeCsv, 24'd1);
				3:       program_registers(8'($urandom), 24'($urandom_range(0, 5000)));
				default: program_registers(8'($urandom), 24'($urandom));
			endcase
			burst_left = $urandom_range(1, 16);
			for (int n = 0; n < PhaseRequests; n++) begin
				row.req = random_cycle();
				send_cycle(row.req);
				expected_results.insert(expected_results.size(), advance_drive(row.req));
				burst_left--;
				if (burst_left == 0 && n != PhaseRequests - 1) begin
					idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					if (idle > 0) begin
						req_ch.valid <= 1'b0;
						repeat (idle) @(posedge clk);
					end
					burst_left = $urandom_range(1, 16);
				end
			end
			req_ch.valid <= 1'b0;
		end

		drain_results();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result side: rotate through stall patterns, with a long hold-off now and then
	initial begin : result_sink
		int cyc;
		res_ch.ready <= 1'b0;
		cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if ((cyc % 1000) >= HoldStart && (cyc % 1000) < HoldStart + HoldLen) begin
				res_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 64) % 4)
					0:       res_ch.ready <= 1'b1;
					1:       res_ch.ready <= 1'($urandom_range(0, 1));
					2:       res_ch.ready <= ($urandom_range(0, 7) != 0);
					default: res_ch.ready <= ((cyc % 5) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		drive_result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing outstanding",
					results_seen));
			end else begin
				want = expected_results.pop_front();
				compare_field("drive_state", {29'h0, res_ch.drive_state},
					{29'h0, want.drive_state});
				compare_field("control_word", {22'h0, res_ch.control_word},
					{22'h0, want.control_word});
				compare_field("mode_request", {24'h0, res_ch.mode_request},
					{24'h0, want.mode_request});
				compare_field("velocity_setpoint", res_ch.velocity_setpoint,
					want.velocity_setpoint);
				compare_field("state_event", {31'h0, res_ch.state_event},
					{31'h0, want.state_event});
				compare_field("error_event", {31'h0, res_ch.error_event},
					{31'h0, want.error_event});
				compare_field("estop_active", {31'h0, res_ch.estop_active},
					{31'h0, want.estop_active});
				compare_field("estop_event", {31'h0, res_ch.estop_event},
					{31'h0, want.estop_event});
				compare_field("drive_ready", {31'h0, res_ch.drive_ready},
					{31'h0, want.drive_ready});
				compare_field("drive_enabled", {31'h0, res_ch.drive_enabled},
					{31'h0, want.drive_enabled});
			end
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/cia_dsc_pkg.sv
hw/rtl/cia_dsc_in_if.sv
hw/rtl/cia_dsc_out_if.sv
hw/rtl/cia_dsc_cfg_if.sv
hw/rtl/cia_dsc_ramp.sv
hw/rtl/cia402_drive_state_controller.sv
hw/rtl/cia_dsc_checker.sv
test/tb_cia402_drive_state_controller.sv
